// ===== design/signed_integer_to_radix_text_assert.svh =====
// Assertion macros used by the radix text converter datapath.
`ifndef SIGNED_INTEGER_TO_RADIX_TEXT_ASSERT_SVH
`define SIGNED_INTEGER_TO_RADIX_TEXT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define SITRT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define SITRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/sitrt_pkg.sv =====
// Shared constants, types and microcode table of the radix text converter.
package sitrt_pkg;

  localparam int NUMBER_WIDTH = 32;
  localparam int MAX_SYMBOLS  = 32;
  localparam int SYM_W        = 8;
  localparam int RADIX_W      = 6;
  localparam int DIGIT_W      = $clog2(MAX_SYMBOLS);
  localparam int SYM_GRP_W    = $clog2(MAX_SYMBOLS / 8);
  localparam int STACK_DEPTH  = NUMBER_WIDTH;
  localparam int STACK_AW     = $clog2(STACK_DEPTH);
  localparam int COUNT_W      = STACK_AW + 1;
  localparam int NUM_BYTES    = NUMBER_WIDTH / 8;
  localparam int BYTE_IDX_W   = (NUM_BYTES > 1) ? $clog2(NUM_BYTES) : 1;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 64;
  localparam int PC_W         = 4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RADIX     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SYM_FIRST = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_SYM_LAST  = CFG_IDX_W'(4);

  // Characters
  localparam logic [SYM_W-1:0] CH_NUL   = 8'h00;
  localparam logic [SYM_W-1:0] CH_TAB   = 8'h09;
  localparam logic [SYM_W-1:0] CH_CR    = 8'h0D;
  localparam logic [SYM_W-1:0] CH_SPACE = 8'h20;
  localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_CHK_START,
    OP_CHK_STEP,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_PUSH,
    OP_EMIT_SIGN,
    OP_EMIT_DIGIT
  } op_t;

  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_REQ,
    C_CHECKED,
    C_CHK_MORE,
    C_INVALID,
    C_DIV_MORE,
    C_Q_MORE,
    C_POSITIVE,
    C_OUT_FULL,
    C_EMIT_MORE
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic req;
    logic checked;
    logic cfg_ok;
    logic chk_more;
    logic div_more;
    logic q_more;
    logic negative;
    logic out_full;
    logic last_digit;
  } stat_t;

  localparam logic [PC_W-1:0] PC_IDLE       = PC_W'(0);
  localparam logic [PC_W-1:0] PC_CFG_TEST   = PC_W'(1);
  localparam logic [PC_W-1:0] PC_CHK_START  = PC_W'(2);
  localparam logic [PC_W-1:0] PC_CHK_LOOP   = PC_W'(3);
  localparam logic [PC_W-1:0] PC_VALID_TEST = PC_W'(4);
  localparam logic [PC_W-1:0] PC_DIGIT      = PC_W'(5);
  localparam logic [PC_W-1:0] PC_DIV_LOOP   = PC_W'(6);
  localparam logic [PC_W-1:0] PC_PUSH       = PC_W'(7);
  localparam logic [PC_W-1:0] PC_SIGN_TEST  = PC_W'(8);
  localparam logic [PC_W-1:0] PC_SIGN       = PC_W'(9);
  localparam logic [PC_W-1:0] PC_EMIT       = PC_W'(10);
  localparam logic [PC_W-1:0] PC_DONE       = PC_W'(11);

  // Jump to target when cond holds, else fall through to the next step.
  localparam ucode_t UCODE [2**PC_W] = '{
    '{OP_LOAD,       C_NO_REQ,    PC_IDLE},       // wait for a request
    '{OP_NOP,        C_CHECKED,   PC_VALID_TEST}, // symbol set already checked
    '{OP_CHK_START,  C_NEXT,      PC_IDLE},
    '{OP_CHK_STEP,   C_CHK_MORE,  PC_CHK_LOOP},
    '{OP_NOP,        C_INVALID,   PC_IDLE},       // bad symbol set: drop
    '{OP_DIV_START,  C_NEXT,      PC_IDLE},
    '{OP_DIV_STEP,   C_DIV_MORE,  PC_DIV_LOOP},   // one quotient byte per pass
    '{OP_PUSH,       C_Q_MORE,    PC_DIGIT},
    '{OP_NOP,        C_POSITIVE,  PC_EMIT},       // also settles stack read
    '{OP_EMIT_SIGN,  C_OUT_FULL,  PC_SIGN},
    '{OP_EMIT_DIGIT, C_EMIT_MORE, PC_EMIT},
    '{OP_NOP,        C_ALWAYS,    PC_IDLE},
    '{OP_NOP,        C_ALWAYS,    PC_IDLE},
    '{OP_NOP,        C_ALWAYS,    PC_IDLE},
    '{OP_NOP,        C_ALWAYS,    PC_IDLE},
    '{OP_NOP,        C_ALWAYS,    PC_IDLE}
  };

  function automatic logic sym_forbidden(logic [SYM_W-1:0] c);
    return (c == CH_NUL) || (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_SPACE) ||
           ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

// ===== design/sitrt_ctrl.sv =====
// Microcode sequencer: step counter, control store and jump condition logic.
module sitrt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  sitrt_pkg::stat_t stat,
  output sitrt_pkg::op_t   op,
  output logic             busy
);

  logic [sitrt_pkg::PC_W-1:0] pc;
  logic [sitrt_pkg::PC_W-1:0] pc_next;
  sitrt_pkg::ucode_t          uword;
  logic                       jump;

  assign uword = sitrt_pkg::UCODE[pc];
  assign op    = uword.op;
  assign busy  = (pc != sitrt_pkg::PC_IDLE);

  always_comb begin
    unique case (uword.cond)
      sitrt_pkg::C_NEXT:      jump = 1'b0;
      sitrt_pkg::C_ALWAYS:    jump = 1'b1;
      sitrt_pkg::C_NO_REQ:    jump = !stat.req;
      sitrt_pkg::C_CHECKED:   jump = stat.checked;
      sitrt_pkg::C_CHK_MORE:  jump = stat.chk_more;
      sitrt_pkg::C_INVALID:   jump = !stat.cfg_ok;
      sitrt_pkg::C_DIV_MORE:  jump = stat.div_more;
      sitrt_pkg::C_Q_MORE:    jump = stat.q_more;
      sitrt_pkg::C_POSITIVE:  jump = !stat.negative;
      sitrt_pkg::C_OUT_FULL:  jump = stat.out_full;
      sitrt_pkg::C_EMIT_MORE: jump = stat.out_full || !stat.last_digit;
      default:                jump = 1'b0;
    endcase
    pc_next = jump ? uword.target : pc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= sitrt_pkg::PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ===== design/sitrt_datapath.sv =====
// Datapath: config registers, symbol-set check, digit divider, digit stack, output register.
`include "signed_integer_to_radix_text_assert.svh"

module sitrt_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [sitrt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sitrt_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                in_valid,
  input  logic signed [sitrt_pkg::NUMBER_WIDTH-1:0] number,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic [sitrt_pkg::SYM_W-1:0]         symbol,
  output logic                                last_symbol,
  input  sitrt_pkg::op_t                      op,
  output sitrt_pkg::stat_t                    stat
);

  logic [sitrt_pkg::RADIX_W-1:0]      radix;
  logic [sitrt_pkg::SYM_W-1:0]        syms [sitrt_pkg::MAX_SYMBOLS];
  logic [sitrt_pkg::SYM_GRP_W-1:0]    sym_grp;
  logic                               checked;
  logic                               cfg_ok;
  logic [sitrt_pkg::DIGIT_W-1:0]      chk_idx;
  logic                               dup;
  logic [sitrt_pkg::DIGIT_W-1:0]      sym_addr;
  logic [sitrt_pkg::SYM_W-1:0]        sym_sel;

  logic [sitrt_pkg::NUMBER_WIDTH-1:0] quotient;
  logic [sitrt_pkg::NUMBER_WIDTH-1:0] magnitude;
  logic                               negative;
  logic [sitrt_pkg::BYTE_IDX_W-1:0]   byte_idx;
  logic [sitrt_pkg::BYTE_IDX_W-1:0]   top_byte;
  logic [7:0]                         cur_byte;
  logic [7:0]                         new_byte;
  logic [sitrt_pkg::DIGIT_W-1:0]      rem;
  logic [sitrt_pkg::DIGIT_W-1:0]      div_rem;
  logic [sitrt_pkg::DIGIT_W:0]        div_trial;

  logic [sitrt_pkg::COUNT_W-1:0]      digit_count;
  logic [sitrt_pkg::COUNT_W-1:0]      digit_count_next;
  logic [sitrt_pkg::DIGIT_W-1:0]      digit_stack [sitrt_pkg::STACK_DEPTH];
  logic [sitrt_pkg::STACK_AW-1:0]     rd_addr;
  logic [sitrt_pkg::DIGIT_W-1:0]      rd_data;

  logic                               accept;
  logic                               out_free;
  logic                               emit;

  assign accept   = (op == sitrt_pkg::OP_LOAD) && in_valid;
  assign out_free = !out_valid || !out_stall;
  assign emit     = out_free &&
                    ((op == sitrt_pkg::OP_EMIT_SIGN) || (op == sitrt_pkg::OP_EMIT_DIGIT));
  assign sym_grp  = sitrt_pkg::SYM_GRP_W'(cfg_index - sitrt_pkg::CFG_SYM_FIRST);

  // The sym_sel read port is shared by the check pass and emission.
  assign sym_addr  = (op == sitrt_pkg::OP_CHK_STEP) ? chk_idx : rd_data;
  assign sym_sel   = syms[sym_addr];
  assign magnitude = number[sitrt_pkg::NUMBER_WIDTH-1] ? (~number + 1'b1) : number;

  // Duplicate: the symbol under test matches one at a lower digit.
  always_comb begin
    dup = 1'b0;
    for (int j = 0; j < sitrt_pkg::MAX_SYMBOLS; j++) begin
      if ((sitrt_pkg::DIGIT_W'(j) < chk_idx) && (syms[j] == sym_sel)) begin
        dup = 1'b1;
      end
    end
  end

  // Highest nonzero byte; the zero bytes above it divide to zero, remainder zero.
  always_comb begin
    top_byte = '0;
    for (int i = 1; i < sitrt_pkg::NUM_BYTES; i++) begin
      if (quotient[i*8 +: 8] != '0) begin
        top_byte = sitrt_pkg::BYTE_IDX_W'(i);
      end
    end
  end

  // Eight restoring steps of long division by the radix on one quotient byte.
  assign cur_byte = quotient[{byte_idx, 3'b000} +: 8];
  always_comb begin
    div_rem  = rem;
    new_byte = '0;
    div_trial = '0;
    for (int b = 7; b >= 0; b--) begin
      div_trial = {div_rem, cur_byte[b]};
      if (div_trial >= radix) begin
        div_rem     = sitrt_pkg::DIGIT_W'(div_trial - radix);
        new_byte[b] = 1'b1;
      end else begin
        div_rem     = sitrt_pkg::DIGIT_W'(div_trial);
      end
    end
  end

  always_comb begin
    digit_count_next = digit_count;
    if (accept) begin
      digit_count_next = '0;
    end else if (op == sitrt_pkg::OP_PUSH) begin
      digit_count_next = digit_count + 1'b1;
    end else if (emit && (op == sitrt_pkg::OP_EMIT_DIGIT)) begin
      digit_count_next = digit_count - 1'b1;
    end
  end

  // Stack read tracks the top of stack for the coming cycle.
  assign rd_addr = sitrt_pkg::STACK_AW'(digit_count_next - 1'b1);

  always_comb begin
    stat.req        = in_valid;
    stat.checked    = checked;
    stat.cfg_ok     = cfg_ok;
    stat.chk_more   = (chk_idx != sitrt_pkg::DIGIT_W'(sitrt_pkg::MAX_SYMBOLS - 1));
    stat.div_more   = (byte_idx != '0);
    stat.q_more     = (quotient != '0) &&
                      (digit_count != sitrt_pkg::COUNT_W'(sitrt_pkg::STACK_DEPTH - 1));
    stat.negative   = negative;
    stat.out_full   = !out_free;
    stat.last_digit = (digit_count == sitrt_pkg::COUNT_W'(1));
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      radix       <= '0;
      checked     <= 1'b0;
      out_valid   <= 1'b0;
      digit_count <= '0;
      quotient    <= '0;
      for (int s = 0; s < sitrt_pkg::MAX_SYMBOLS; s++) begin
        syms[s] <= '0;
      end
    end else begin
      if (cfg_write) begin
        checked <= 1'b0;
        case (cfg_index) inside
          sitrt_pkg::CFG_RADIX: begin
            radix <= cfg_data[sitrt_pkg::RADIX_W-1:0];
          end
          [sitrt_pkg::CFG_SYM_FIRST:sitrt_pkg::CFG_SYM_LAST]: begin
            for (int k = 0; k < 8; k++) begin
              syms[{sym_grp, 3'(k)}] <= cfg_data[8*k +: 8];
            end
          end
          default: begin
          end
        endcase
      end
      if ((op == sitrt_pkg::OP_CHK_STEP) &&
          (chk_idx == sitrt_pkg::DIGIT_W'(sitrt_pkg::MAX_SYMBOLS - 1))) begin
        checked <= 1'b1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      digit_count <= digit_count_next;
      if (accept) begin
        quotient <= magnitude;
      end else if (op == sitrt_pkg::OP_DIV_STEP) begin
        quotient[{byte_idx, 3'b000} +: 8] <= new_byte;
      end
    end
  end

  // Check pass, divider and output payload
  always_ff @(posedge clk) begin
    case (op)
      sitrt_pkg::OP_LOAD: begin
        if (in_valid) begin
          negative <= number[sitrt_pkg::NUMBER_WIDTH-1];
        end
      end
      sitrt_pkg::OP_CHK_START: begin
        chk_idx <= '0;
        cfg_ok  <= (radix >= sitrt_pkg::RADIX_W'(2)) &&
                   (radix <= sitrt_pkg::RADIX_W'(sitrt_pkg::MAX_SYMBOLS));
      end
      sitrt_pkg::OP_CHK_STEP: begin
        if (sitrt_pkg::RADIX_W'(chk_idx) < radix) begin
          if (sitrt_pkg::sym_forbidden(sym_sel) || dup) begin
            cfg_ok <= 1'b0;
          end
        end
        chk_idx <= chk_idx + 1'b1;
      end
      sitrt_pkg::OP_DIV_START: begin
        rem      <= '0;
        byte_idx <= top_byte;
      end
      sitrt_pkg::OP_DIV_STEP: begin
        rem      <= div_rem;
        byte_idx <= byte_idx - 1'b1;
      end
      sitrt_pkg::OP_EMIT_SIGN: begin
        if (out_free) begin
          symbol      <= sitrt_pkg::CH_MINUS;
          last_symbol <= 1'b0;
        end
      end
      sitrt_pkg::OP_EMIT_DIGIT: begin
        if (out_free) begin
          symbol      <= sym_sel;
          last_symbol <= (digit_count == sitrt_pkg::COUNT_W'(1));
        end
      end
      default: begin
      end
    endcase
  end

  // Digit stack memory; a read in the cycle of a push returns old data,
  // the sign-test step after the last push gives the read time to settle.
  always_ff @(posedge clk) begin
    if (op == sitrt_pkg::OP_PUSH) begin
      digit_stack[digit_count[sitrt_pkg::STACK_AW-1:0]] <= rem;
    end
    rd_data <= digit_stack[rd_addr];
  end

  `SITRT_ASSERT_SAME(a_push_fits, op == sitrt_pkg::OP_PUSH, digit_count < sitrt_pkg::COUNT_W'(sitrt_pkg::STACK_DEPTH), "digit stack overflow")
  `SITRT_ASSERT_SAME(a_emit_has_digit, op == sitrt_pkg::OP_EMIT_DIGIT, digit_count != '0, "digit emitted from empty stack")
  `SITRT_ASSERT_NEXT(a_rem_below_radix, op == sitrt_pkg::OP_DIV_STEP, sitrt_pkg::RADIX_W'(rem) < radix, "division remainder not below radix")

endmodule

// ===== design/signed_integer_to_radix_text.sv =====
// Top level: signed integer to text in a configurable radix.
// Usage:
//   A request on number (valid/stall) carries one signed 32-bit value. The block
//   returns its text one symbol per output request, most significant digit
//   first, a '-' first for negatives, last_symbol set on the final symbol.
//   The radix and its symbols come from the write port (index 0 radix, 1..4 eight
//   symbols each). With a bad radix or symbol set a request is taken and yields nothing.
// Timing:
//   in_stall is low only while the sequencer idles; one request is in work at a time.
//   Per request: setup, then per digit a divider start, one divider pass per
//   quotient byte (1 to 4) up to its highest nonzero one, and a push, then one
//   output symbol per cycle while out_stall is low. The first request after reset
//   or any config write adds a symbol-set check.
//   First symbol appears after the digits are all produced.
// Reset (rst, synchronous): radix, symbol set, digit count and quotient go to zero
//   (symbol set invalid), the output register empties and the sequencer returns to idle.
// Stall: the output register holds its symbol while out_stall is high; the
//   sequencer waits at the emit step, and a new request is taken once the last
//   symbol is loaded even if it has not yet been taken.
module signed_integer_to_radix_text (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      cfg_write,
  input  logic [sitrt_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [sitrt_pkg::CFG_DATA_W-1:0]          cfg_data,
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic signed [sitrt_pkg::NUMBER_WIDTH-1:0] number,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic [sitrt_pkg::SYM_W-1:0]               symbol,
  output logic                                      last_symbol
);

  sitrt_pkg::stat_t stat;
  sitrt_pkg::op_t   op;
  logic             busy;

  assign in_stall = busy;

  sitrt_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .op   (op),
    .busy (busy)
  );

  sitrt_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .number      (number),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .symbol      (symbol),
    .last_symbol (last_symbol),
    .op          (op),
    .stat        (stat)
  );

endmodule
